>>> rtl/cpst_pkg.sv
// ----------------------------------------------------------------------------
// cpst_pkg
// shared types for the convex polygon separating axis test
// ----------------------------------------------------------------------------
package cpst_pkg;

	// one vertex as it travels from the front to the test engine
	typedef struct packed {
		logic        mode;
		logic        last;
		logic [31:0] x;
		logic [31:0] y;
	} vtx_t;

	// one test result
	typedef struct packed {
		logic        hit;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [30:0] depth;
		logic        status;
	} result_t;

	// quotient bits of the unit normal divider, enough for 16384
	localparam int QUOT_BITS = 15;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_EDGE0,
		ST_EDGE1,
		ST_EDGE2,
		ST_NORM,
		ST_SQ,
		ST_SQ2,
		ST_SQRT,
		ST_DIVI,
		ST_DIV,
		ST_NSET,
		ST_PROJ,
		ST_CMP,
		ST_FL0,
		ST_FL1,
		ST_FL2,
		ST_OUT
	} eng_state_t;

endpackage

>>> rtl/cpst_fifo.sv
// ----------------------------------------------------------------------------
// cpst_fifo
// short vertex queue between the input front and the test engine
// ----------------------------------------------------------------------------
module cpst_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cpst_pkg::vtx_t push_item,
	output logic           full,
	input  logic           pop,
	output cpst_pkg::vtx_t head,
	output logic           empty
);
	import cpst_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	vtx_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

endmodule

>>> rtl/cpst_front.sv
// ----------------------------------------------------------------------------
// cpst_front
// input side: takes vertex beats, clamps coordinates, feeds the queue
// ----------------------------------------------------------------------------
module cpst_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [63:0]    s_tdata,
	input  logic           s_tlast,
	input  logic           s_tuser,
	input  logic           full,
	output logic           push,
	output cpst_pkg::vtx_t push_item
);
	import cpst_pkg::*;

	localparam logic signed [48:0] LIM_HI = (49'sd1 <<< (COORD_WIDTH - 1)) - 49'sd1;
	localparam logic signed [48:0] LIM_LO = -LIM_HI - 49'sd1;

	function automatic logic [31:0] clamp(input logic [31:0] v);
		logic signed [48:0] w;
		w = $signed({{17{v[31]}}, v});
		if (w > LIM_HI) return LIM_HI[31:0];
		else if (w < LIM_LO) return LIM_LO[31:0];
		else return v;
	endfunction

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		push_item.mode = s_tuser;
		push_item.last = s_tlast;
		push_item.x    = clamp(s_tdata[31:0]);
		push_item.y    = clamp(s_tdata[63:32]);
	end

endmodule

>>> rtl/cpst_engine.sv
// ----------------------------------------------------------------------------
// cpst_engine
// vertex stores and the sequenced separating axis test with result register
// ----------------------------------------------------------------------------
module cpst_engine #(
	parameter int MAX_VERTICES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cpst_pkg::vtx_t    head,
	input  logic              empty,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output cpst_pkg::result_t res
);
	import cpst_pkg::*;

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int SW = 32 + CW;
	localparam int PW = SW + CW + 1;
	localparam int DW = PW + 1;
	localparam int FW = DW + 16;

	localparam logic [32:0] NORM_TOP  = 33'h0_4000_0000;
	localparam logic [32:0] NORM_LOW  = 33'h0_2000_0000;
	localparam logic [32:0] NORM_FAST = 33'h0_0020_0000;

	eng_state_t state_q, state_d;

	// control
	logic [CW-1:0]        cnt_a_q, cnt_b_q;
	logic                 ovf_q;
	logic signed [SW-1:0] sum_q [4];
	logic                 pass_q;
	logic [AW-1:0]        ei_q;
	logic [CW-1:0]        pk_q;
	logic                 psel_q, pdone_q;
	logic                 pv_s1, pv_s2;
	logic                 have_q, sep_q, status_q;
	logic                 m_tvalid_q;

	// payload
	logic [63:0]          mem_a [MAX_VERTICES];
	logic [63:0]          mem_b [MAX_VERTICES];
	logic [63:0]          rd_a_q, rd_b_q;
	logic                 rd_sel_q;
	logic [63:0]          vi_q;
	logic [32:0]          mx_q, my_q;
	logic                 sgnx_q, sgny_q;
	logic signed [63:0]   prod0_q, prod1_q;
	logic [63:0]          sq_n_q, sq_r_q, sq_bit_q;
	logic [45:0]          remx_q, remy_q, dv_q;
	logic [QUOT_BITS-1:0] qx_q, qy_q;
	logic [3:0]           dcnt_q;
	logic signed [15:0]   nx_q, ny_q;
	logic                 psel_s1, pfirst_s1, psel_s2, pfirst_s2;
	logic signed [47:0]   lo_a_q, hi_a_q, lo_b_q, hi_b_q;
	logic signed [48:0]   best_q;
	logic signed [15:0]   bnx_q, bny_q;
	logic signed [PW-1:0] cpax_q, cpbx_q, cpay_q, cpby_q;
	logic signed [FW-1:0] fpx_q, fpy_q;
	logic signed [15:0]   rnx_q, rny_q;
	logic [30:0]          rdepth_q;
	result_t              out_q;

	// combinational
	logic                 rsel, issue;
	logic [AW-1:0]        raddr, ej;
	logic [63:0]          rd_v;
	logic [CW-1:0]        n_edge, n_proj;
	logic                 last_edge, degen, out_free;
	logic signed [32:0]   vix, viy, vjx, vjy, dxe, dye;
	logic [32:0]          m_max;
	logic signed [31:0]   mul_a0, mul_b0, mul_a1, mul_b1;
	logic [63:0]          sq_t;
	logic signed [47:0]   dot;
	logic signed [48:0]   d1, d2, dmin;
	logic                 sep_c, upd_c;
	logic signed [DW-1:0] dxv, dyv;
	logic signed [FW:0]   fsum;
	logic [48:0]          dq_w;
	logic [45:0]          len_w;
	logic                 ld_a, ld_b, room;

	assign rd_v     = rd_sel_q ? rd_b_q : rd_a_q;
	assign n_edge   = pass_q ? cnt_b_q : cnt_a_q;
	assign n_proj   = psel_q ? cnt_b_q : cnt_a_q;
	assign last_edge = (CW'(ei_q) == n_edge - 1'b1);
	assign ej       = last_edge ? '0 : ei_q + 1'b1;
	assign degen    = ovf_q || (cnt_a_q < CW'(3)) || (cnt_b_q < CW'(3));
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign res      = out_q;

	// edge of the current axis: vi from the first read, vj on the read port
	assign vix = $signed({vi_q[63], vi_q[63:32]});
	assign viy = $signed({vi_q[31], vi_q[31:0]});
	assign vjx = $signed({rd_v[63], rd_v[63:32]});
	assign vjy = $signed({rd_v[31], rd_v[31:0]});
	// axis is the perpendicular (-ey, ex); polygon A edges run the other way
	assign dxe = pass_q ? (viy - vjy) : (vjy - viy);
	assign dye = pass_q ? (vjx - vix) : (vix - vjx);

	assign m_max = (mx_q > my_q) ? mx_q : my_q;
	assign sq_t  = sq_r_q + sq_bit_q;
	assign len_w = sq_r_q[45:0];

	// shared multiplier pair: squares of the scaled axis, then projections
	always_comb begin
		if (state_q == ST_SQ) begin
			mul_a0 = {2'b00, mx_q[29:0]};
			mul_b0 = {2'b00, mx_q[29:0]};
			mul_a1 = {2'b00, my_q[29:0]};
			mul_b1 = {2'b00, my_q[29:0]};
		end else begin
			mul_a0 = $signed(rd_v[63:32]);
			mul_b0 = {{16{nx_q[15]}}, nx_q};
			mul_a1 = $signed(rd_v[31:0]);
			mul_b1 = {{16{ny_q[15]}}, ny_q};
		end
	end

	assign dot   = prod0_q[47:0] + prod1_q[47:0];
	assign sep_c = (lo_a_q >= hi_b_q) || (lo_b_q >= hi_a_q);
	assign d1    = 49'(hi_b_q) - 49'(lo_a_q);
	assign d2    = 49'(hi_a_q) - 49'(lo_b_q);
	assign dmin  = (d1 < d2) ? d1 : d2;
	assign upd_c = !sep_c && (!have_q || dmin < best_q);

	assign dxv  = cpbx_q - cpax_q;
	assign dyv  = cpby_q - cpay_q;
	assign fsum = fpx_q + fpy_q;
	assign dq_w = best_q + 49'sd8192;

	assign room = head.mode ? (cnt_b_q < CW'(MAX_VERTICES)) : (cnt_a_q < CW'(MAX_VERTICES));
	assign ld_a = pop && !head.mode && room;
	assign ld_b = pop && head.mode && room;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rsel    = pass_q;
		raddr   = ei_q;
		issue   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (!empty) begin
					pop = 1'b1;
					if (head.mode && head.last) state_d = ST_START;
				end
			end
			ST_START: state_d = degen ? ST_OUT : ST_EDGE0;
			ST_EDGE0: state_d = ST_EDGE1;
			ST_EDGE1: begin
				raddr   = ej;
				state_d = ST_EDGE2;
			end
			ST_EDGE2: state_d = (vi_q == rd_v) ? ST_OUT : ST_NORM;
			ST_NORM: begin
				if (m_max < NORM_TOP && m_max >= NORM_LOW) state_d = ST_SQ;
			end
			ST_SQ:   state_d = ST_SQ2;
			ST_SQ2:  state_d = ST_SQRT;
			ST_SQRT: if (sq_bit_q[0]) state_d = ST_DIVI;
			ST_DIVI: state_d = ST_DIV;
			ST_DIV:  if (dcnt_q == '0) state_d = ST_NSET;
			ST_NSET: state_d = ST_PROJ;
			ST_PROJ: begin
				if (!pdone_q) begin
					issue = 1'b1;
					rsel  = psel_q;
					raddr = pk_q[AW-1:0];
				end else if (!pv_s1 && !pv_s2) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (last_edge && pass_q) state_d = (sep_q || sep_c) ? ST_OUT : ST_FL0;
				else state_d = ST_EDGE0;
			end
			ST_FL0: state_d = ST_FL1;
			ST_FL1: state_d = ST_FL2;
			ST_FL2: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			ovf_q      <= 1'b0;
			for (int k = 0; k < 4; k++) sum_q[k] <= '0;
			pass_q     <= 1'b0;
			ei_q       <= '0;
			pk_q       <= '0;
			psel_q     <= 1'b0;
			pdone_q    <= 1'b0;
			pv_s1      <= 1'b0;
			pv_s2      <= 1'b0;
			have_q     <= 1'b0;
			sep_q      <= 1'b0;
			status_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= issue;
			pv_s2   <= pv_s1;
			if (pop) begin
				if (!room) ovf_q <= 1'b1;
				if (ld_a) begin
					cnt_a_q  <= cnt_a_q + 1'b1;
					sum_q[0] <= sum_q[0] + $signed({{CW{head.x[31]}}, head.x});
					sum_q[1] <= sum_q[1] + $signed({{CW{head.y[31]}}, head.y});
				end
				if (ld_b) begin
					cnt_b_q  <= cnt_b_q + 1'b1;
					sum_q[2] <= sum_q[2] + $signed({{CW{head.x[31]}}, head.x});
					sum_q[3] <= sum_q[3] + $signed({{CW{head.y[31]}}, head.y});
				end
			end
			case (state_q)
				ST_START: begin
					pass_q <= 1'b0;
					ei_q   <= '0;
					have_q <= 1'b0;
					sep_q  <= 1'b0;
					if (degen) status_q <= 1'b1;
				end
				ST_EDGE2: if (vi_q == rd_v) status_q <= 1'b1;
				ST_NSET: begin
					pk_q    <= '0;
					psel_q  <= 1'b0;
					pdone_q <= 1'b0;
				end
				ST_PROJ: begin
					if (!pdone_q) begin
						if (pk_q == n_proj - 1'b1) begin
							pk_q <= '0;
							if (psel_q) pdone_q <= 1'b1;
							else psel_q <= 1'b1;
						end else begin
							pk_q <= pk_q + 1'b1;
						end
					end
				end
				ST_CMP: begin
					sep_q <= sep_q | sep_c;
					if (upd_c) have_q <= 1'b1;
					if (last_edge) begin
						pass_q <= 1'b1;
						ei_q   <= '0;
					end else begin
						ei_q <= ei_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						cnt_a_q  <= '0;
						cnt_b_q  <= '0;
						ovf_q    <= 1'b0;
						status_q <= 1'b0;
						for (int k = 0; k < 4; k++) sum_q[k] <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// vertex stores
	always_ff @(posedge clk) begin
		if (ld_a) mem_a[cnt_a_q[AW-1:0]] <= {head.x, head.y};
		if (ld_b) mem_b[cnt_b_q[AW-1:0]] <= {head.x, head.y};
		rd_a_q   <= mem_a[raddr];
		rd_b_q   <= mem_b[raddr];
		rd_sel_q <= rsel;
	end

	// datapath
	always_ff @(posedge clk) begin
		prod0_q   <= mul_a0 * mul_b0;
		prod1_q   <= mul_a1 * mul_b1;
		psel_s1   <= rsel;
		pfirst_s1 <= (pk_q == '0);
		psel_s2   <= psel_s1;
		pfirst_s2 <= pfirst_s1;
		case (state_q)
			ST_EDGE1: vi_q <= rd_v;
			ST_EDGE2: begin
				sgnx_q <= dxe[32];
				sgny_q <= dye[32];
				mx_q   <= dxe[32] ? 33'(-dxe) : dxe;
				my_q   <= dye[32] ? 33'(-dye) : dye;
			end
			ST_NORM: begin
				// right shifts only ever come first, left shifts are exact
				if (m_max >= NORM_TOP) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end else if (m_max < NORM_FAST) begin
					mx_q <= mx_q << 8;
					my_q <= my_q << 8;
				end else if (m_max < NORM_LOW) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
				end
			end
			ST_SQ2: begin
				sq_n_q   <= prod0_q + prod1_q;
				sq_r_q   <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_DIVI: begin
				remx_q <= ({16'd0, mx_q[29:0]} << 14) + (len_w >> 1);
				remy_q <= ({16'd0, my_q[29:0]} << 14) + (len_w >> 1);
				dv_q   <= len_w << 14;
				qx_q   <= '0;
				qy_q   <= '0;
				dcnt_q <= 4'(QUOT_BITS - 1);
			end
			ST_DIV: begin
				if (remx_q >= dv_q) begin
					remx_q <= remx_q - dv_q;
					qx_q   <= {qx_q[QUOT_BITS-2:0], 1'b1};
				end else begin
					qx_q <= {qx_q[QUOT_BITS-2:0], 1'b0};
				end
				if (remy_q >= dv_q) begin
					remy_q <= remy_q - dv_q;
					qy_q   <= {qy_q[QUOT_BITS-2:0], 1'b1};
				end else begin
					qy_q <= {qy_q[QUOT_BITS-2:0], 1'b0};
				end
				dv_q   <= dv_q >> 1;
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_NSET: begin
				nx_q <= sgnx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
				ny_q <= sgny_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
			end
			ST_CMP: begin
				if (upd_c) begin
					best_q <= dmin;
					bnx_q  <= nx_q;
					bny_q  <= ny_q;
				end
			end
			ST_FL0: begin
				cpax_q <= sum_q[0] * $signed({1'b0, cnt_b_q});
				cpay_q <= sum_q[1] * $signed({1'b0, cnt_b_q});
				cpbx_q <= sum_q[2] * $signed({1'b0, cnt_a_q});
				cpby_q <= sum_q[3] * $signed({1'b0, cnt_a_q});
			end
			ST_FL1: begin
				fpx_q <= dxv * bnx_q;
				fpy_q <= dyv * bny_q;
			end
			ST_FL2: begin
				// normal points from the centroid of a toward that of b
				rnx_q    <= fsum[FW] ? -bnx_q : bnx_q;
				rny_q    <= fsum[FW] ? -bny_q : bny_q;
				rdepth_q <= (|dq_w[48:45]) ? 31'h7FFF_FFFF : dq_w[44:14];
			end
			ST_OUT: begin
				if (out_free) begin
					out_q.status <= status_q;
					if (status_q || sep_q) begin
						out_q.hit   <= 1'b0;
						out_q.nx    <= '0;
						out_q.ny    <= '0;
						out_q.depth <= '0;
					end else begin
						out_q.hit   <= 1'b1;
						out_q.nx    <= rnx_q;
						out_q.ny    <= rny_q;
						out_q.depth <= rdepth_q;
					end
				end
			end
			default: ;
		endcase
		if (pv_s2) begin
			if (psel_s2) begin
				if (pfirst_s2 || dot < lo_b_q) lo_b_q <= dot;
				if (pfirst_s2 || dot > hi_b_q) hi_b_q <= dot;
			end else begin
				if (pfirst_s2 || dot < lo_a_q) lo_a_q <= dot;
				if (pfirst_s2 || dot > hi_a_q) hi_a_q <= dot;
			end
		end
	end

endmodule

>>> rtl/convex_polygon_sat_test.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_test
// separating axis collision test of two convex polygons in fixed point
// ----------------------------------------------------------------------------
// Vertex beats enter on the s_ channel: tuser selects polygon A (0) or B (1),
// tlast marks the last vertex of a polygon. The last vertex of B starts the
// test, which gives one result beat on the m_ channel (tuser is the status).
// Vertices are taken at one per cycle into a four-entry queue while it is not
// full, and stored at one per cycle while the engine loads. The test walks
// every edge of A then of B as an axis; each axis runs a normalize of one or
// eight bits a step, a 32-step square root, a 15-step divider pair for the
// unit normal and one projection per vertex through the shared multiplier
// pair. After the last axis the centroid steps run before output on a hit. While
// a test runs the queue fills and then s_tready drops. A result waiting on
// m_tready does not stop the next pair from loading and testing; the next
// result then holds the engine in its output step until the first is taken.
// Reset empties both polygons and the queue and clears the vertex sums; no
// clearing pass over the stores.
// ----------------------------------------------------------------------------
module convex_polygon_sat_test #(
	parameter int MAX_VERTICES = 8,
	parameter int COORD_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // vertex_x, vertex_y
	input  logic        s_tlast,   // last_vertex
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // hit, normal_x, normal_y, overlap_depth
	output logic        m_tuser    // status
);
	import cpst_pkg::*;

	vtx_t    push_item;
	vtx_t    head;
	logic    push, full, pop, empty;
	result_t res;

	cpst_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push),
		.push_item(push_item)
	);

	cpst_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	cpst_engine #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.res     (res)
	);

	assign m_tdata = {res.depth, res.ny, res.nx, res.hit};
	assign m_tuser = res.status;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// separating axis collision test: directed polygon pairs, then random pairs
// ----------------------------------------------------------------------------
// Vertex beats are sent through one task. Each beat also updates a local
// copy of the polygon state, which predicts the result of every last vertex
// of B. A checker process compares each result beat, field by field, with
// the oldest prediction. The run covers several idle and stall settings, one
// long output hold-off, and pauses that wait for every result to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cpst_pkg::*;

	localparam int  NV        = 8;
	localparam int  CYC_LIMIT = 3000000;
	localparam int  TAIL      = 2000;
	localparam longint QMAX   = 64'sh7FFFFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;

	convex_polygon_sat_test i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// polygon state as the block should hold it
	longint ax[NV], ay[NV], bx[NV], by[NV];
	int     cnt_a, cnt_b;
	longint sum_ax, sum_ay, sum_bx, sum_by;
	bit     overfull;

	result_t hit_q[$];
	int      errs = 0;
	int      cycles = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      hold_left = 0;

	// shape scratch
	longint px[16], py[16];
	int     pn;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errs++;
	endtask

	function automatic longint unsigned sqrt_floor(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	task automatic unit_normal(input longint dx, input longint dy,
			output longint nx, output longint ny);
		longint unsigned mx, my, m, len, qx, qy;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		m = mx > my ? mx : my;
		while (m >= (64'd1 << 30)) begin mx >>= 1; my >>= 1; m >>= 1; end
		while (m < (64'd1 << 29)) begin mx <<= 1; my <<= 1; m <<= 1; end
		len = sqrt_floor(mx * mx + my * my);
		qx = (mx * 16384 + len / 2) / len;
		qy = (my * 16384 + len / 2) / len;
		nx = dx < 0 ? -longint'(qx) : longint'(qx);
		ny = dy < 0 ? -longint'(qy) : longint'(qy);
	endtask

	task automatic span(input bit of_b, input longint nx, input longint ny,
			output longint lo, output longint hi);
		longint d;
		int n;
		n = of_b ? cnt_b : cnt_a;
		for (int i = 0; i < n; i++) begin
			d = of_b ? bx[i] * nx + by[i] * ny : ax[i] * nx + ay[i] * ny;
			if (i == 0 || d < lo) lo = d;
			if (i == 0 || d > hi) hi = d;
		end
	endtask

	function automatic bit zero_edge(input bit of_b);
		int n, j;
		n = of_b ? cnt_b : cnt_a;
		for (int i = 0; i < n; i++) begin
			j = (i + 1) % n;
			if (of_b ? (bx[i] == bx[j] && by[i] == by[j])
					: (ax[i] == ax[j] && ay[i] == ay[j]))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// axis sweep, stopping at the first separating axis; returns overlap on every axis with the best axis
	task automatic axis_sweep(output bit hit, output longint bnx, output longint bny,
			output longint bdep);
		bit have;
		int n, j;
		longint ex, ey, nx, ny, lo_a, hi_a, lo_b, hi_b, d1, d2, d;
		have = 0;
		hit = 1;
		for (int pass = 0; pass < 2 && hit; pass++) begin
			n = pass ? cnt_b : cnt_a;
			for (int i = 0; i < n && hit; i++) begin
				j = (i + 1) % n;
				ex = pass ? bx[j] - bx[i] : ax[i] - ax[j];
				ey = pass ? by[j] - by[i] : ay[i] - ay[j];
				unit_normal(-ey, ex, nx, ny);
				span(0, nx, ny, lo_a, hi_a);
				span(1, nx, ny, lo_b, hi_b);
				if (lo_a >= hi_b || lo_b >= hi_a)
					hit = 0;
				else begin
					d1 = hi_b - lo_a;
					d2 = hi_a - lo_b;
					d = d1 < d2 ? d1 : d2;
					if (!have || d < bdep) begin
						have = 1;
						bdep = d;
						bnx = nx;
						bny = ny;
					end
				end
			end
		end
	endtask

	task automatic predict_vertex(input bit mode, input logic signed [31:0] x,
			input logic signed [31:0] y, input bit last);
		result_t r;
		bit hit, st;
		longint nx, ny, dep, cdx, cdy, dq;
		if (!mode) begin
			if (cnt_a < NV) begin
				ax[cnt_a] = x; ay[cnt_a] = y; cnt_a++;
				sum_ax += x; sum_ay += y;
			end else overfull = 1;
		end else begin
			if (cnt_b < NV) begin
				bx[cnt_b] = x; by[cnt_b] = y; cnt_b++;
				sum_bx += x; sum_by += y;
			end else overfull = 1;
		end
		if (!mode || !last) return;
		hit = 0; nx = 0; ny = 0; dq = 0;
		st = overfull || cnt_a < 3 || cnt_b < 3 || zero_edge(0) || zero_edge(1);
		if (!st) begin
			axis_sweep(hit, nx, ny, dep);
			if (hit) begin
				cdx = sum_bx * cnt_a - sum_ax * cnt_b;
				cdy = sum_by * cnt_a - sum_ay * cnt_b;
				if (cdx * nx + cdy * ny < 0) begin nx = -nx; ny = -ny; end
				dq = (dep + 8192) >>> 14;
				if (dq > QMAX) dq = QMAX;
			end else begin
				nx = 0; ny = 0;
			end
		end
		r.hit = hit;
		r.nx = nx[15:0];
		r.ny = ny[15:0];
		r.depth = dq[30:0];
		r.status = st;
		hit_q = {hit_q, r};
		cnt_a = 0; cnt_b = 0;
		sum_ax = 0; sum_ay = 0; sum_bx = 0; sum_by = 0;
		overfull = 0;
	endtask

	// one vertex beat; ready is taken at the falling edge before the accepting edge
	task automatic send_vertex(input bit mode, input longint x, input longint y,
			input bit last);
		bit rdy;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y[31:0], x[31:0]};
		s_tlast <= last;
		s_tuser <= mode;
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy) break;
		end
		predict_vertex(mode, x[31:0], y[31:0], last);
	endtask

	task automatic send_shape(input bit mode, input bit last);
		for (int i = 0; i < pn; i++)
			send_vertex(mode, px[i], py[i], last && i == pn - 1);
	endtask

	function automatic longint rnd32();
		return longint'(signed'($urandom()));
	endfunction

	// convex shape around a center; kind 0 triangle, 1 square, 2 octagon
	task automatic make_shape(input longint cx, input longint cy, input longint r,
			input int kind, input bit flip);
		longint h, tx, ty;
		h = r / 2;
		case (kind)
			0: begin
				pn = 3;
				px[0] = cx;     py[0] = cy + r;
				px[1] = cx - r; py[1] = cy - r;
				px[2] = cx + r; py[2] = cy - r;
			end
			1: begin
				pn = 4;
				px[0] = cx + r; py[0] = cy + r;
				px[1] = cx - r; py[1] = cy + r;
				px[2] = cx - r; py[2] = cy - r;
				px[3] = cx + r; py[3] = cy - r;
			end
			default: begin
				pn = 8;
				px[0] = cx + r; py[0] = cy + h;
				px[1] = cx + h; py[1] = cy + r;
				px[2] = cx - h; py[2] = cy + r;
				px[3] = cx - r; py[3] = cy + h;
				px[4] = cx - r; py[4] = cy - h;
				px[5] = cx - h; py[5] = cy - r;
				px[6] = cx + h; py[6] = cy - r;
				px[7] = cx + r; py[7] = cy - h;
			end
		endcase
		if (flip)
			for (int i = 0; i < pn / 2; i++) begin
				tx = px[i]; ty = py[i];
				px[i] = px[pn - 1 - i]; py[i] = py[pn - 1 - i];
				px[pn - 1 - i] = tx; py[pn - 1 - i] = ty;
			end
	endtask

	task automatic noise_shape(input int n);
		pn = n;
		for (int i = 0; i < n; i++) begin
			px[i] = rnd32();
			py[i] = rnd32();
		end
		if (n > 1 && $urandom_range(3) == 0) begin
			px[n - 1] = px[0];
			py[n - 1] = py[0];
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		wait (hit_q.size() == 0);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic random_pair();
		longint cx, cy, r, r2;
		if ($urandom_range(9) < 8) begin
			cx = $urandom_range(1 << 20) - (1 << 19);
			cy = $urandom_range(1 << 20) - (1 << 19);
			r = $urandom_range(1 << 24, 1 << 10);
			cx = cx << $urandom_range(8);
			make_shape(cx, cy, r, $urandom_range(2), $urandom_range(1));
			send_shape(0, $urandom_range(1));
			r2 = $urandom_range(1 << 24, 1 << 10);
			cx += longint'($urandom_range(3 * (r + r2))) - (3 * (r + r2)) / 2;
			cy += longint'($urandom_range(3 * (r + r2))) - (3 * (r + r2)) / 2;
			make_shape(cx, cy, r2, $urandom_range(2), $urandom_range(1));
			send_shape(1, 1);
		end else begin
			noise_shape($urandom_range(10, 1));
			send_shape(0, $urandom_range(1));
			noise_shape($urandom_range(10, 1));
			send_shape(1, 1);
		end
	endtask

	task automatic test_directed();
		longint mx, mn;
		mx = QMAX;
		mn = -QMAX - 1;
		// full range square against a small one: depth saturates
		pn = 4;
		px[0] = mx; py[0] = mx; px[1] = mn; py[1] = mx;
		px[2] = mn; py[2] = mn; px[3] = mx; py[3] = mn;
		send_shape(0, 1);
		make_shape(0, 0, 1 << 16, 1, 0);
		send_shape(1, 1);
		// touching squares
		make_shape(0, 0, 1 << 16, 1, 0);
		send_shape(0, 1);
		make_shape(2 << 16, 0, 1 << 16, 1, 1);
		send_shape(1, 1);
		// identical polygons: centroid direction is zero
		make_shape(5 << 16, -3 << 16, 3 << 16, 2, 0);
		send_shape(0, 0);
		send_shape(1, 1);
		// too few vertices in B
		make_shape(0, 0, 1 << 16, 0, 0);
		send_shape(0, 1);
		send_vertex(1, 0, 0, 0);
		send_vertex(1, 1 << 16, 0, 1);
		// repeated vertex across the wrap in A
		pn = 4;
		px[0] = 0; py[0] = 0; px[1] = 1 << 16; py[1] = 0;
		px[2] = 0; py[2] = 1 << 16; px[3] = 0; py[3] = 0;
		send_shape(0, 1);
		make_shape(0, 0, 1 << 15, 0, 0);
		send_shape(1, 1);
		// nine vertices in A overflow the store
		make_shape(0, 0, 1 << 18, 2, 0);
		send_shape(0, 0);
		send_vertex(0, 1, 1, 1);
		make_shape(0, 0, 1 << 16, 0, 1);
		send_shape(1, 1);
	endtask

	task automatic test_phases();
		int idl[4] = '{0, 58, 0, 35};
		int stl[4] = '{0, 0, 58, 35};
		for (int p = 0; p < 4; p++) begin
			idle_pct = idl[p];
			stall_pct = stl[p];
			repeat (20) random_pair();
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_left = 6000;
		repeat (6) random_pair();
		wait_drain();
	endtask

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// result checker: outputs are stable at the falling edge before acceptance
	always @(negedge clk) begin
		result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_q.size() == 0) begin
				report("unexpected beat", m_tdata, 0);
			end else begin
				w = hit_q.pop_front();
				if (m_tdata[0] !== w.hit) report("hit", m_tdata[0], w.hit);
				if (m_tdata[16:1] !== w.nx) report("normal_x", m_tdata[16:1], w.nx);
				if (m_tdata[32:17] !== w.ny) report("normal_y", m_tdata[32:17], w.ny);
				if (m_tdata[63:33] !== w.depth)
					report("depth", m_tdata[63:33], w.depth);
				if (m_tuser !== w.status) report("status", m_tuser, w.status);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		cnt_a = 0; cnt_b = 0;
		sum_ax = 0; sum_ay = 0; sum_bx = 0; sum_by = 0;
		overfull = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drain();
		test_phases();
		wait_drain();
		test_backpressure();
		if (errs == 0 && hit_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
